### design/utf8_codepoint_classifier_macros.svh
// Assertion macros for the UTF-8 code point classifier.
`ifndef UTF8_CODEPOINT_CLASSIFIER_MACROS_SVH
`define UTF8_CODEPOINT_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define UCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ucc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define UCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ucc assertion failed");

`endif

### design/ucc_pkg.sv
// Types, constants and class functions for the UTF-8 code point classifier.
package ucc_pkg;

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

    localparam int STICKY_N = 26;
    localparam int KS_START_N = 26;
    localparam int KS_END_N = 23;

    localparam logic [20:0] STICKY_SET [STICKY_N] = '{
        21'h2E, 21'h2C, 21'h21, 21'h3F, 21'h3A, 21'h3B, 21'h29, 21'h5D, 21'h7D,
        21'h25, 21'h22, 21'h2026, 21'h060C, 21'h061B, 21'h061F, 21'h0964,
        21'h0965, 21'h104A, 21'h104B, 21'h104C, 21'h104D, 21'h104F, 21'h201D,
        21'h2019, 21'h00BB, 21'h203A
    };

    localparam logic [20:0] KS_START_SET [KS_START_N] = '{
        21'hFF0C, 21'hFF0E, 21'hFF01, 21'hFF1A, 21'hFF1B, 21'hFF1F, 21'h3001,
        21'h3002, 21'h30FB, 21'hFF09, 21'h3015, 21'h3009, 21'h300B, 21'h300D,
        21'h300F, 21'h3011, 21'h3017, 21'h3019, 21'h301B, 21'h30FC, 21'h3005,
        21'h303B, 21'h309D, 21'h309E, 21'h30FD, 21'h30FE
    };

    localparam logic [20:0] KS_END_SET [KS_END_N] = '{
        21'h22, 21'h28, 21'h5B, 21'h7B, 21'h00A1, 21'h00BF, 21'h201C, 21'h2018,
        21'h201A, 21'h201E, 21'h00AB, 21'h2039, 21'h2E18, 21'hFF08, 21'h3014,
        21'h3008, 21'h300A, 21'h300C, 21'h300E, 21'h3010, 21'h3016, 21'h3018,
        21'h301A
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    // Decoded value before classification.
    typedef struct packed {
        logic [20:0] code_point;
        logic        was_stray;
        logic        was_truncated;
        logic        last_of_text;
    } t_raw_item;

    typedef struct packed {
        logic [20:0] code_point;
        logic        is_cjk;
        logic        is_latin_alnum;
        logic        is_left_sticky;
        logic        is_kinsoku_start;
        logic        is_kinsoku_end;
        logic        is_glue;
        logic        was_stray;
        logic        was_truncated;
        logic        last_of_text;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic in_range(input logic [20:0] v, input logic [20:0] lo,
                                      input logic [20:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic cjk_class(input logic [20:0] v);
        return in_range(v, 21'h4E00, 21'h9FFF) || in_range(v, 21'h3400, 21'h4DBF) ||
               in_range(v, 21'h20000, 21'h2A6DF) || in_range(v, 21'h2A700, 21'h2CEAF) ||
               in_range(v, 21'hF900, 21'hFAFF) || in_range(v, 21'h3000, 21'h30FF) ||
               in_range(v, 21'h3130, 21'h318F) || in_range(v, 21'hAC00, 21'hD7AF) ||
               in_range(v, 21'hFF00, 21'hFFEF);
    endfunction

    function automatic logic latin_class(input logic [20:0] v);
        return in_range(v, 21'h41, 21'h5A) || in_range(v, 21'h61, 21'h7A) ||
               in_range(v, 21'h30, 21'h39) || in_range(v, 21'h00C0, 21'h024F) ||
               in_range(v, 21'h1E00, 21'h1EFF);
    endfunction

    function automatic logic glue_class(input logic [20:0] v);
        return (v == 21'h00A0) || (v == 21'h202F) || (v == 21'h2060) ||
               (v == 21'hFEFF);
    endfunction

    function automatic logic sticky_class(input logic [20:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < STICKY_N; k++) begin
            hit = hit | (STICKY_SET[k] == v);
        end
        return hit;
    endfunction

    function automatic logic ks_start_class(input logic [20:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KS_START_N; k++) begin
            hit = hit | (KS_START_SET[k] == v);
        end
        return hit;
    endfunction

    function automatic logic ks_end_class(input logic [20:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KS_END_N; k++) begin
            hit = hit | (KS_END_SET[k] == v);
        end
        return hit;
    endfunction

endpackage

### design/ucc_decode.sv
// Front end: takes bytes, tracks owed continuations, and queues decoded values.
module ucc_decode
    import ucc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_item,
    input  t_q_status i_q_status,
    output logic      o_q_push,
    output t_raw_item o_q_item
);

    logic [1:0]  r_owed;
    logic [1:0]  n_owed;
    logic [20:0] r_partial;
    logic [20:0] n_partial;
    logic        accept;
    logic [20:0] shifted;

    assign accept  = i_push && !i_q_status.full;
    assign shifted = {r_partial[14:0], i_item.text_byte[5:0]};

    always_comb begin
        n_owed    = r_owed;
        n_partial = r_partial;
        o_q_push  = 1'b0;
        o_q_item  = '{code_point: '0, was_stray: 1'b0, was_truncated: 1'b0,
                      last_of_text: i_item.end_of_text};
        if (accept) begin
            if (r_owed == 2'd0) begin
                if (!i_item.text_byte[7]) begin
                    o_q_push            = 1'b1;
                    o_q_item.code_point = {13'd0, i_item.text_byte};
                end else if (!i_item.text_byte[6]) begin
                    o_q_push            = 1'b1;
                    o_q_item.code_point = REPLACEMENT;
                    o_q_item.was_stray  = 1'b1;
                end else begin
                    if (!i_item.text_byte[5]) begin
                        n_partial = {16'd0, i_item.text_byte[4:0]};
                        n_owed    = 2'd1;
                    end else if (!i_item.text_byte[4]) begin
                        n_partial = {17'd0, i_item.text_byte[3:0]};
                        n_owed    = 2'd2;
                    end else begin
                        n_partial = {18'd0, i_item.text_byte[2:0]};
                        n_owed    = 2'd3;
                    end
                    // End of text on a lead byte: emit what the lead carries.
                    if (i_item.end_of_text) begin
                        o_q_push               = 1'b1;
                        o_q_item.code_point    = n_partial;
                        o_q_item.was_truncated = 1'b1;
                        n_partial              = '0;
                        n_owed                 = 2'd0;
                    end
                end
            end else begin
                n_owed = r_owed - 2'd1;
                if (r_owed == 2'd1) begin
                    o_q_push            = 1'b1;
                    o_q_item.code_point = shifted;
                    n_partial           = '0;
                end else if (i_item.end_of_text) begin
                    o_q_push               = 1'b1;
                    o_q_item.code_point    = shifted;
                    o_q_item.was_truncated = 1'b1;
                    n_partial              = '0;
                    n_owed                 = 2'd0;
                end else begin
                    n_partial = shifted;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed    <= 2'd0;
            r_partial <= '0;
        end else begin
            r_owed    <= n_owed;
            r_partial <= n_partial;
        end
    end

endmodule

### design/ucc_queue.sv
// Short queue of decoded values between the front and back ends.
module ucc_queue
    import ucc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_raw_item i_item,
    input  logic      i_pop,
    output t_raw_item o_item,
    output t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_raw_item     r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/ucc_classify.sv
// Back end: classifies the queue head and holds it in the result register.
module ucc_classify
    import ucc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_raw_item i_q_item,
    input  t_q_status i_q_status,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_result
);

    logic      r_valid;
    t_out_item r_result;
    t_out_item n_result;

    // Load whenever the register is free or its item leaves this cycle.
    assign o_q_pop  = !i_q_status.empty && (!r_valid || i_pop);
    assign o_empty  = !r_valid;
    assign o_result = r_result;

    always_comb begin
        n_result.code_point       = i_q_item.code_point;
        n_result.is_cjk           = cjk_class(i_q_item.code_point);
        n_result.is_latin_alnum   = latin_class(i_q_item.code_point);
        n_result.is_left_sticky   = sticky_class(i_q_item.code_point);
        n_result.is_kinsoku_start = ks_start_class(i_q_item.code_point);
        n_result.is_kinsoku_end   = ks_end_class(i_q_item.code_point);
        n_result.is_glue          = glue_class(i_q_item.code_point);
        n_result.was_stray        = i_q_item.was_stray;
        n_result.was_truncated    = i_q_item.was_truncated;
        n_result.last_of_text     = i_q_item.last_of_text;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_result <= n_result;
        end
    end

endmodule

### design/utf8_codepoint_classifier.sv
// Top level of the UTF-8 code point classifier: decode, queue, classify.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------
//  input   | push / full        | i_item   (text_byte, end_of_text)
//  result  | pop / empty        | o_result (code point and flags)
//
// One byte is taken per cycle while full is low; at most one item follows.
// A decoded value passes through the queue into the result register, which
// loads it when free or while its held item is popped; it can then be popped.
// full rises only when the queue of QUEUE_DEPTH decoded values fills under
// a stalled result side. Reset is synchronous and clears decoder state,
// queue pointers and the result valid bit.
`include "utf8_codepoint_classifier_macros.svh"

module utf8_codepoint_classifier
    import ucc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_result
);

    t_q_status q_status;
    logic      q_push;
    logic      q_pop;
    t_raw_item q_in_item;
    t_raw_item q_out_item;

    assign full = q_status.full;

    ucc_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_q_status (q_status),
        .o_q_push   (q_push),
        .o_q_item   (q_in_item)
    );

    ucc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (q_in_item),
        .i_pop    (q_pop),
        .o_item   (q_out_item),
        .o_status (q_status)
    );

    ucc_classify u_classify (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_item   (q_out_item),
        .i_q_status (q_status),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

    // The decoder never writes into a full queue.
    `UCC_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, q_push, !q_status.full)
    // A queued item moves up whenever the result register has room.
    `UCC_ASSERT_NEXT(a_back_advances, i_clk, i_rst_n, !q_status.empty && (empty || pop), !empty)
    // Stray bytes always come out as the replacement character.
    `UCC_ASSERT_NOW(a_stray_value, i_clk, i_rst_n, !empty && o_result.was_stray, o_result.code_point == REPLACEMENT)
    // A cut-short sequence only ever closes a text.
    `UCC_ASSERT_NOW(a_trunc_is_last, i_clk, i_rst_n, !empty && o_result.was_truncated, o_result.last_of_text)

endmodule
